// File: rtl/dsop_pkg.sv
`timescale 1ns / 1ps
package dsop_pkg;

	localparam int MaxLengthBytes = 4;

	localparam logic [7:0] TagSequence = 8'h30;
	localparam logic [7:0] TagInteger  = 8'h02;
	localparam logic [7:0] TagOctets   = 8'h04;
	localparam logic [7:0] TagOid      = 8'h06;
	localparam logic [7:0] LongFormBit = 8'h80;
	localparam logic [7:0] LenCountMsk = 8'h7F;

	typedef enum logic [4:0] {
		PH_IDLE, PH_SEQ_TAG, PH_SEQ_LEN, PH_VER_TAG, PH_VER_LEN, PH_VER_VAL,
		PH_ALG_TAG, PH_ALG_LEN, PH_OID_TAG, PH_OID_LEN, PH_OID_VAL, PH_ALG_SKIP,
		PH_LIST_TAG, PH_LIST_LEN, PH_REC_TAG, PH_REC_LEN, PH_INT_TAG, PH_INT_LEN,
		PH_INT_VAL, PH_HASH_TAG, PH_HASH_LEN, PH_HASH_VAL, PH_REC_SKIP
	} phase_t;

	typedef enum logic [2:0] {
		RK_VERSION = 3'd0, RK_OID = 3'd1, RK_HEADER = 3'd2, RK_HASH = 3'd3,
		RK_END = 3'd4
	} rkind_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [31:0] total_length;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  record_kind;
		logic [31:0] value;
		logic [31:0] group_number;
		logic        last_of_record;
		logic        message_done;
		logic        status;
	} out_item_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] position;
		logic [31:0] content_end;
		logic [31:0] algorithm_end;
		logic [31:0] list_end;
		logic [31:0] record_end;
		logic [31:0] field_end;
		logic [31:0] len_acc;
		logic [2:0]  len_left;
		logic [31:0] value_acc;
		logic [31:0] cur_group;
	} pstate_t;

	function automatic logic is_len(phase_t p);
		return p == PH_SEQ_LEN || p == PH_VER_LEN || p == PH_ALG_LEN ||
		       p == PH_OID_LEN || p == PH_LIST_LEN || p == PH_REC_LEN ||
		       p == PH_INT_LEN || p == PH_HASH_LEN;
	endfunction

endpackage

// File: rtl/dsop_step.sv
`timescale 1ns / 1ps
module dsop_step #(
	parameter int MAX_LENGTH_BYTES = dsop_pkg::MaxLengthBytes
) (
	input  dsop_pkg::pstate_t  cur,
	input  dsop_pkg::in_item_t item,
	output dsop_pkg::pstate_t  nxt,
	output logic               has_out,
	output dsop_pkg::out_item_t res
);
	import dsop_pkg::*;

	// bounds for a length field of the given phase
	function automatic logic [31:0] bound_of(pstate_t s);
		case (s.phase)
			PH_OID_LEN:              return s.algorithm_end;
			PH_REC_LEN:              return s.list_end;
			PH_INT_LEN, PH_HASH_LEN: return s.record_end;
			default:                 return s.content_end;
		endcase
	endfunction

	// length failure handling
	function automatic void len_fail(inout pstate_t s, inout logic dn, inout logic st);
		if (s.phase == PH_REC_LEN) begin
			dn = 1'b1; st = 1'b0; s.phase = PH_IDLE;
		end else if (s.phase == PH_INT_LEN || s.phase == PH_HASH_LEN) begin
			s.phase = PH_REC_SKIP;
		end else begin
			dn = 1'b1; st = 1'b1; s.phase = PH_IDLE;
		end
	endfunction

	logic        emit, done, stat, last;
	rkind_t      rk;
	logic [31:0] rv, rg;
	pstate_t     s;
	logic [32:0] e;
	logic [32:0] pe;
	logic [6:0]  n;
	logic [7:0]  b;
	logic        lfin;

	// one item: byte step then settle passes
	always_comb begin
		s = cur;
		emit = 1'b0; done = 1'b0; stat = 1'b0; last = 1'b0;
		rk = RK_END; rv = '0; rg = '0;
		b = item.data_byte;
		e = '0; pe = '0; n = '0; lfin = 1'b0;
		if (!item.kind) begin
			s = '0;
			s.content_end = item.total_length;
			s.phase = PH_SEQ_TAG;
		end else if (cur.phase != PH_IDLE) begin
			s.position = cur.position + 32'd1;
			if (s.phase == PH_VER_TAG && b != TagInteger) s.phase = PH_ALG_TAG;
			if (s.phase == PH_INT_TAG && b != TagInteger) s.phase = PH_HASH_TAG;
			if (is_len(s.phase)) begin
				if (s.len_left == 3'd0) begin
					if (!b[7]) begin
						s.len_acc = {24'd0, b};
						lfin = 1'b1;
					end else begin
						n = b[6:0] & LenCountMsk[6:0];
						pe = {1'b0, s.position} + {26'd0, n};
						if (n == 7'd0 || n > 7'(MAX_LENGTH_BYTES) ||
						    pe > {1'b0, bound_of(s)})
							len_fail(s, done, stat);
						else begin
							s.len_left = n[2:0];
							s.len_acc = '0;
						end
					end
				end else begin
					s.len_acc = {s.len_acc[23:0], b};
					s.len_left = s.len_left - 3'd1;
					lfin = (s.len_left == 3'd0);
				end
				if (lfin) begin
					e = {1'b0, s.position} + {1'b0, s.len_acc};
					case (s.phase)
						PH_SEQ_LEN: s.phase = PH_VER_TAG;
						PH_VER_LEN:
							if (e > {1'b0, s.content_end}) begin
								done = 1'b1; stat = 1'b1; s.phase = PH_IDLE;
							end else begin
								s.field_end = e[31:0]; s.value_acc = '0;
								s.phase = PH_VER_VAL;
							end
						PH_ALG_LEN:
							if (e > {1'b0, s.content_end}) begin
								done = 1'b1; stat = 1'b1; s.phase = PH_IDLE;
							end else begin
								s.algorithm_end = e[31:0]; s.phase = PH_OID_TAG;
							end
						PH_OID_LEN:
							if (e > {1'b0, s.algorithm_end}) begin
								done = 1'b1; stat = 1'b1; s.phase = PH_IDLE;
							end else begin
								s.field_end = e[31:0]; s.phase = PH_OID_VAL;
							end
						PH_LIST_LEN: begin
							s.list_end = (e > {1'b0, s.content_end}) ?
								s.content_end : e[31:0];
							s.phase = PH_REC_TAG;
						end
						PH_REC_LEN:
							if (e > {1'b0, s.list_end}) begin
								done = 1'b1; stat = 1'b0; s.phase = PH_IDLE;
							end else begin
								s.record_end = e[31:0]; s.cur_group = '0;
								s.phase = PH_INT_TAG;
							end
						PH_INT_LEN:
							if (e > {1'b0, s.record_end}) s.phase = PH_REC_SKIP;
							else begin
								s.field_end = e[31:0]; s.cur_group = '0;
								s.phase = PH_INT_VAL;
							end
						PH_HASH_LEN:
							if (e > {1'b0, s.record_end}) s.phase = PH_REC_SKIP;
							else begin
								s.field_end = e[31:0];
								emit = 1'b1; rk = RK_HEADER; rv = s.len_acc;
								rg = s.cur_group; last = (s.len_acc == 32'd0);
								s.phase = PH_HASH_VAL;
							end
						default: ;
					endcase
				end
			end else begin
				case (s.phase)
					PH_SEQ_TAG, PH_ALG_TAG, PH_LIST_TAG:
						if (b != TagSequence) begin
							done = 1'b1; stat = 1'b1; s.phase = PH_IDLE;
						end else s.phase = phase_t'(s.phase + 5'd1);
					PH_REC_TAG:
						if (b != TagSequence) begin
							done = 1'b1; stat = 1'b0; s.phase = PH_IDLE;
						end else s.phase = PH_REC_LEN;
					PH_VER_TAG: s.phase = PH_VER_LEN;
					PH_INT_TAG: s.phase = PH_INT_LEN;
					PH_OID_TAG: s.phase = (b == TagOid) ? PH_OID_LEN : PH_ALG_SKIP;
					PH_HASH_TAG: s.phase = (b == TagOctets) ? PH_HASH_LEN : PH_REC_SKIP;
					PH_VER_VAL: s.value_acc = {s.value_acc[23:0], b};
					PH_INT_VAL: s.cur_group = {s.cur_group[23:0], b};
					PH_OID_VAL: begin
						emit = 1'b1; rk = RK_OID; rv = {24'd0, b};
						last = (s.position >= s.field_end);
					end
					PH_HASH_VAL: begin
						emit = 1'b1; rk = RK_HASH; rv = {24'd0, b}; rg = s.cur_group;
						last = (s.position >= s.field_end);
					end
					default: ;
				endcase
				if (is_len(s.phase)) begin
					s.len_left = '0; s.len_acc = '0;
				end
			end
		end
		// settle: bounded chain of transitions needing no byte
		for (int i = 0; i < 8; i++) begin
			if (is_len(s.phase)) begin
				if (s.len_left == 3'd0 && s.position >= bound_of(s))
					len_fail(s, done, stat);
			end else begin
				case (s.phase)
					PH_SEQ_TAG, PH_ALG_TAG, PH_LIST_TAG:
						if (s.position >= s.content_end) begin
							done = 1'b1; stat = 1'b1; s.phase = PH_IDLE;
						end
					PH_VER_TAG: if (s.position >= s.content_end) s.phase = PH_ALG_TAG;
					PH_VER_VAL:
						if (s.position >= s.field_end) begin
							emit = 1'b1; rk = RK_VERSION; rv = s.value_acc; rg = '0;
							last = 1'b0; s.phase = PH_ALG_TAG;
						end
					PH_OID_TAG: if (s.position >= s.algorithm_end) s.phase = PH_ALG_SKIP;
					PH_OID_VAL: if (s.position >= s.field_end) s.phase = PH_ALG_SKIP;
					PH_ALG_SKIP: if (s.position >= s.algorithm_end) s.phase = PH_LIST_TAG;
					PH_REC_TAG:
						if (s.position >= s.list_end) begin
							done = 1'b1; stat = 1'b0; s.phase = PH_IDLE;
						end
					PH_INT_TAG: if (s.position >= s.record_end) s.phase = PH_HASH_TAG;
					PH_INT_VAL: if (s.position >= s.field_end) s.phase = PH_HASH_TAG;
					PH_HASH_TAG: if (s.position >= s.record_end) s.phase = PH_REC_SKIP;
					PH_HASH_VAL: if (s.position >= s.field_end) s.phase = PH_REC_SKIP;
					PH_REC_SKIP: if (s.position >= s.record_end) s.phase = PH_REC_TAG;
					default: ;
				endcase
			end
		end
		nxt = s;
		has_out = emit | done;
		res.record_kind = emit ? rk : RK_END;
		res.value = emit ? rv : '0;
		res.group_number = emit ? rg : '0;
		res.last_of_record = emit & last;
		res.message_done = done;
		res.status = done & stat;
	end
endmodule

// File: rtl/der_security_object_parser.sv
`timescale 1ns / 1ps
// Streaming DER security object parser. Send a start item (kind 0) with the
// content length, then one content byte per item (kind 1). Items are taken
// every cycle unless the output register is full and stalled: each is
// latched into an input register, decoded against the stored bounds in one
// pass of logic, and at most one result is then registered in the output
// register. Results carry version, raw OID bytes,
// data-group headers and hash bytes; message_done with status ends a message.
module der_security_object_parser #(
	parameter int MAX_LENGTH_BYTES = dsop_pkg::MaxLengthBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // data_byte[7:0], total_length[39:8]
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // value[31:0], group_number[63:32], pad
	output logic [2:0]  m_tuser,  // record_kind[2:0]
	output logic        m_tlast,  // last_of_record
	output logic        message_done,
	output logic        status
);
	import dsop_pkg::*;

	logic      v_s1;
	in_item_t  item_s1;
	pstate_t   st_q, st_nxt;
	logic      has_out;
	out_item_t res, res_q;
	logic      out_v_q;
	logic      adv;

	// stage one advances unless the result register is full and stalled
	assign adv = !(out_v_q && !m_tready);
	assign s_tready = adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= '{kind: s_tuser, data_byte: s_tdata[7:0],
			             total_length: s_tdata[39:8]};
		end
	end

	dsop_step #(.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)) u_step (
		.cur(st_q), .item(item_s1), .nxt(st_nxt), .has_out(has_out), .res(res)
	);

	// parse state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= '0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			if (v_s1) st_q <= st_nxt;
			out_v_q <= v_s1 & has_out;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) res_q <= res;
	end

	assign m_tvalid     = out_v_q;
	assign m_tdata      = {8'd0, res_q.group_number, res_q.value};
	assign m_tuser      = res_q.record_kind;
	assign m_tlast      = res_q.last_of_record;
	assign message_done = res_q.message_done;
	assign status       = res_q.status;

	// status only with done
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!status || message_done)) else $error("status without done");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result lost");
	// ready follows output stall
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("ready low while output empty");
endmodule

// File: sim/der_security_object_parser_tb.sv
`timescale 1ns / 1ps
module der_security_object_parser_tb;
	import dsop_pkg::*;

	typedef logic [7:0] bq_t[$];

	localparam int CycleLimit = 600000;
	localparam int RandomItems = 1000;
	localparam int QuietItems = 150;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        message_done;
	logic        status;

	der_security_object_parser dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .message_done(message_done), .status(status)
	);

	// clock, period 12 ns
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	bit          idle_on;
	bit          hold_req;
	int          failures;
	int          items_sent;
	int unsigned cycles;
	out_item_t   parse_results_q[$];

	// parser shadow state
	phase_t      ph;
	logic [31:0] pos, cend, aend, lend, rend, fend, lacc, vacc, grp;
	logic [2:0]  lleft;
	bit          r_has, r_done, r_last, r_stat;
	rkind_t      r_kind;
	logic [31:0] r_val, r_grp;

	// timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic bit in_length_phase(phase_t p);
		return p == PH_SEQ_LEN || p == PH_VER_LEN || p == PH_ALG_LEN ||
		       p == PH_OID_LEN || p == PH_LIST_LEN || p == PH_REC_LEN ||
		       p == PH_INT_LEN || p == PH_HASH_LEN;
	endfunction

	function automatic logic [63:0] enclosing_end();
		if (ph == PH_OID_LEN) return {32'd0, aend};
		if (ph == PH_REC_LEN) return {32'd0, lend};
		if (ph == PH_INT_LEN || ph == PH_HASH_LEN) return {32'd0, rend};
		return {32'd0, cend};
	endfunction

	function automatic void close_message(bit s);
		r_done = 1'b1;
		r_stat = s;
		ph = PH_IDLE;
	endfunction

	function automatic void report(rkind_t k, logic [31:0] v, logic [31:0] g, bit l);
		r_has = 1'b1;
		r_kind = k;
		r_val = v;
		r_grp = g;
		r_last = l;
	endfunction

	function automatic void start_length(phase_t p);
		ph = p;
		lleft = 3'd0;
		lacc = 32'd0;
	endfunction

	function automatic void length_bad();
		if (ph == PH_REC_LEN) close_message(1'b0);
		else if (ph == PH_INT_LEN || ph == PH_HASH_LEN) ph = PH_REC_SKIP;
		else close_message(1'b1);
	endfunction

	// a complete length is known: check it against its bound and move on
	function automatic void length_complete();
		logic [63:0] e;
		e = {32'd0, pos} + {32'd0, lacc};
		case (ph)
			PH_SEQ_LEN: ph = PH_VER_TAG;
			PH_VER_LEN: begin
				if (e > {32'd0, cend}) close_message(1'b1);
				else begin
					fend = e[31:0];
					vacc = 32'd0;
					ph = PH_VER_VAL;
				end
			end
			PH_ALG_LEN: begin
				if (e > {32'd0, cend}) close_message(1'b1);
				else begin
					aend = e[31:0];
					ph = PH_OID_TAG;
				end
			end
			PH_OID_LEN: begin
				if (e > {32'd0, aend}) close_message(1'b1);
				else begin
					fend = e[31:0];
					ph = PH_OID_VAL;
				end
			end
			PH_LIST_LEN: begin
				if (e > {32'd0, cend}) e = {32'd0, cend};
				lend = e[31:0];
				ph = PH_REC_TAG;
			end
			PH_REC_LEN: begin
				if (e > {32'd0, lend}) close_message(1'b0);
				else begin
					rend = e[31:0];
					grp = 32'd0;
					ph = PH_INT_TAG;
				end
			end
			PH_INT_LEN: begin
				if (e > {32'd0, rend}) ph = PH_REC_SKIP;
				else begin
					fend = e[31:0];
					grp = 32'd0;
					ph = PH_INT_VAL;
				end
			end
			PH_HASH_LEN: begin
				if (e > {32'd0, rend}) ph = PH_REC_SKIP;
				else begin
					fend = e[31:0];
					report(RK_HEADER, lacc, grp, lacc == 32'd0);
					ph = PH_HASH_VAL;
				end
			end
			default: ;
		endcase
	endfunction

	// follow every transition that needs no further byte
	function automatic void resolve_bounds();
		bit go;
		go = 1'b1;
		while (go) begin
			go = 1'b0;
			if (in_length_phase(ph)) begin
				if (lleft == 3'd0 && {32'd0, pos} >= enclosing_end()) begin
					length_bad();
					go = 1'b1;
				end
			end else begin
				case (ph)
					PH_SEQ_TAG, PH_ALG_TAG, PH_LIST_TAG:
						if (pos >= cend) close_message(1'b1);
					PH_VER_TAG:
						if (pos >= cend) begin ph = PH_ALG_TAG; go = 1'b1; end
					PH_VER_VAL:
						if (pos >= fend) begin
							report(RK_VERSION, vacc, 32'd0, 1'b0);
							ph = PH_ALG_TAG;
							go = 1'b1;
						end
					PH_OID_TAG:
						if (pos >= aend) begin ph = PH_ALG_SKIP; go = 1'b1; end
					PH_OID_VAL:
						if (pos >= fend) begin ph = PH_ALG_SKIP; go = 1'b1; end
					PH_ALG_SKIP:
						if (pos >= aend) begin ph = PH_LIST_TAG; go = 1'b1; end
					PH_REC_TAG:
						if (pos >= lend) close_message(1'b0);
					PH_INT_TAG:
						if (pos >= rend) begin ph = PH_HASH_TAG; go = 1'b1; end
					PH_INT_VAL:
						if (pos >= fend) begin ph = PH_HASH_TAG; go = 1'b1; end
					PH_HASH_TAG:
						if (pos >= rend) begin ph = PH_REC_SKIP; go = 1'b1; end
					PH_HASH_VAL:
						if (pos >= fend) begin ph = PH_REC_SKIP; go = 1'b1; end
					PH_REC_SKIP:
						if (pos >= rend) begin ph = PH_REC_TAG; go = 1'b1; end
					default: ;
				endcase
			end
		end
	endfunction

	function automatic void length_byte(logic [7:0] b);
		logic [6:0] n;
		if (lleft == 3'd0) begin
			if (!b[7]) begin
				lacc = {24'd0, b};
				length_complete();
				return;
			end
			n = b[6:0];
			if (n == 7'd0 || n > MaxLengthBytes ||
			    {32'd0, pos} + {57'd0, n} > enclosing_end()) begin
				length_bad();
				return;
			end
			lleft = n[2:0];
			lacc = 32'd0;
			return;
		end
		lacc = {lacc[23:0], b};
		lleft = lleft - 3'd1;
		if (lleft == 3'd0) length_complete();
	endfunction

	function automatic void content_byte(logic [7:0] b);
		bit redo;
		redo = 1'b1;
		pos = pos + 32'd1;
		while (redo) begin
			redo = 1'b0;
			if (in_length_phase(ph)) begin
				length_byte(b);
				break;
			end
			case (ph)
				PH_SEQ_TAG:
					if (b != TagSequence) close_message(1'b1); else start_length(PH_SEQ_LEN);
				PH_VER_TAG:
					if (b == TagInteger) start_length(PH_VER_LEN);
					else begin ph = PH_ALG_TAG; redo = 1'b1; end
				PH_ALG_TAG:
					if (b != TagSequence) close_message(1'b1); else start_length(PH_ALG_LEN);
				PH_OID_TAG:
					if (b == TagOid) start_length(PH_OID_LEN); else ph = PH_ALG_SKIP;
				PH_LIST_TAG:
					if (b != TagSequence) close_message(1'b1); else start_length(PH_LIST_LEN);
				PH_REC_TAG:
					if (b != TagSequence) close_message(1'b0); else start_length(PH_REC_LEN);
				PH_INT_TAG:
					if (b == TagInteger) start_length(PH_INT_LEN);
					else begin ph = PH_HASH_TAG; redo = 1'b1; end
				PH_HASH_TAG:
					if (b == TagOctets) start_length(PH_HASH_LEN); else ph = PH_REC_SKIP;
				PH_VER_VAL: vacc = {vacc[23:0], b};
				PH_INT_VAL: grp = {grp[23:0], b};
				PH_OID_VAL: report(RK_OID, {24'd0, b}, 32'd0, pos >= fend);
				PH_HASH_VAL: report(RK_HASH, {24'd0, b}, grp, pos >= fend);
				default: ;
			endcase
		end
		resolve_bounds();
	endfunction

	function automatic void clear_parse_state();
		ph = PH_IDLE;
		{pos, cend, aend, lend, rend, fend, lacc, vacc, grp} = '0;
		lleft = 3'd0;
	endfunction

	// expected result of one accepted item
	function automatic void predict_parse(bit kind, logic [7:0] b, logic [31:0] total);
		out_item_t r;
		r_has = 1'b0;
		r_done = 1'b0;
		r_stat = 1'b0;
		if (!kind) begin
			clear_parse_state();
			cend = total;
			ph = PH_SEQ_TAG;
			resolve_bounds();
		end else if (ph != PH_IDLE) begin
			content_byte(b);
		end
		if (!r_has && !r_done) return;
		r.record_kind    = r_has ? r_kind : RK_END;
		r.value          = r_has ? r_val : 32'd0;
		r.group_number   = r_has ? r_grp : 32'd0;
		r.last_of_record = r_has ? r_last : 1'b0;
		r.message_done   = r_done;
		r.status         = r_done ? r_stat : 1'b0;
		parse_results_q.push_back(r);
	endfunction

	// sender: one item, then maybe a burst of idle cycles
	task automatic send_item(bit kind, logic [7:0] b, logic [31:0] total);
		int gap;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = kind;
		s_tdata = {total, b};
		do @(posedge clk); while (!s_tready);
		predict_parse(kind, b, total);
		items_sent++;
		if (idle_on && $urandom_range(3) == 0) begin
			gap = $urandom_range(15, 1);
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_bytes(bq_t q);
		foreach (q[i]) send_item(1'b1, q[i], $urandom);
	endtask

	// receiver: random stalls, or one long hold-off on request
	initial begin
		int stall;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				stall = 0;
				while (stall < 400) begin
					@(negedge clk);
					stall++;
				end
				hold_req = 1'b0;
				m_tready = 1'b1;
			end else if (idle_on && $urandom_range(7) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(15, 1) - 1) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (parse_results_q.size() == 0) begin
				$display("%0t: unexpected result kind %0d value %h", $time, m_tuser,
					m_tdata[31:0]);
				failures++;
			end else begin
				e = parse_results_q.pop_front();
				if (m_tuser !== e.record_kind || m_tdata[31:0] !== e.value ||
				    m_tdata[63:32] !== e.group_number || m_tlast !== e.last_of_record ||
				    message_done !== e.message_done || status !== e.status) begin
					$display("%0t: mismatch expected kind %0d val %h grp %h last %b done %b st %b",
						$time, e.record_kind, e.value, e.group_number, e.last_of_record,
						e.message_done, e.status);
					$display("%0t:          actual   kind %0d val %h grp %h last %b done %b st %b",
						$time, m_tuser, m_tdata[31:0], m_tdata[63:32], m_tlast,
						message_done, status);
					failures++;
				end
			end
		end
	end

	// DER length in short or long form, long form sometimes padded
	function automatic void put_length(ref bq_t q, input int unsigned n);
		int need, nb;
		if (n < 128 && $urandom_range(3) != 0) begin
			q.push_back(n[7:0]);
			return;
		end
		need = n < 256 ? 1 : n < 65536 ? 2 : n < 24'hFFFFFF ? 3 : 4;
		nb = $urandom_range(MaxLengthBytes, need);
		q.push_back(LongFormBit | nb[7:0]);
		for (int i = nb - 1; i >= 0; i--) q.push_back(8'((n >> (8 * i)) & 8'hFF));
	endfunction

	function automatic void put_tlv(ref bq_t dst, input logic [7:0] tag, input bq_t body);
		dst.push_back(tag);
		put_length(dst, body.size());
		foreach (body[i]) dst.push_back(body[i]);
	endfunction

	function automatic bq_t random_bytes(int n);
		bq_t q;
		repeat (n) q.push_back(8'($urandom));
		return q;
	endfunction

	// well-formed security object with random content
	function automatic bq_t build_object();
		bq_t inner, alg, list, rec, msg;
		if ($urandom_range(2) != 0) put_tlv(inner, TagInteger, random_bytes($urandom_range(5, 1)));
		put_tlv(alg, TagOid, random_bytes($urandom_range(6)));
		if ($urandom_range(1)) begin
			alg.push_back(8'h05);
			alg.push_back(8'h00);
		end
		put_tlv(inner, TagSequence, alg);
		repeat ($urandom_range(4)) begin
			rec = {};
			if ($urandom_range(4) != 0) put_tlv(rec, TagInteger, random_bytes($urandom_range(5, 1)));
			if ($urandom_range(5) == 0) put_tlv(rec, 8'h0C, random_bytes($urandom_range(3)));
			if ($urandom_range(4) != 0) put_tlv(rec, TagOctets, random_bytes($urandom_range(8)));
			put_tlv(list, TagSequence, rec);
		end
		put_tlv(inner, TagSequence, list);
		put_tlv(msg, TagSequence, inner);
		return msg;
	endfunction

	// send one object, clean or damaged in one of several ways
	task automatic send_object(bq_t msg, int damage);
		int unsigned total;
		int idx;
		total = msg.size();
		case (damage)
			1: begin
				idx = $urandom_range(msg.size() - 1);
				msg[idx] = $urandom;
			end
			2: total = msg.size() + $urandom_range(6) - 3;
			3: total = $urandom;
			4: msg = msg[0:$urandom_range(msg.size() - 1)];
			5: repeat ($urandom_range(4, 1)) msg.push_back(8'($urandom));
			default: ;
		endcase
		send_item(1'b0, 8'($urandom), total);
		send_bytes(msg);
	endtask

	// stop offering, then wait until every expected result has come out
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (parse_results_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_zero_and_idle_bytes();
		send_item(1'b1, 8'hFF, 32'hFFFF_FFFF);
		send_item(1'b0, 8'h00, 32'd0);
		send_item(1'b1, 8'h00, 32'd0);
	endtask

	task automatic test_hand_built();
		// object with version, oid, one good and one damaged record
		send_item(1'b0, 8'h00, 32'd33);
		send_bytes('{8'h30, 8'h81, 8'h1E, 8'h02, 8'h01, 8'h00, 8'h30, 8'h04, 8'h06, 8'h02,
			8'h2A, 8'hFF, 8'h30, 8'h11, 8'h30, 8'h07, 8'h02, 8'h01, 8'h01, 8'h04, 8'h02,
			8'hFF, 8'h00, 8'h30, 8'h06, 8'h02, 8'h09, 8'h04, 8'h00, 8'h04, 8'h00});
		// oid running past its identifier
		send_item(1'b0, 8'h00, 32'd8);
		send_bytes('{8'h30, 8'h06, 8'h30, 8'h02, 8'h06, 8'h05});
	endtask

	task automatic test_length_extremes();
		send_item(1'b0, 8'hFF, 32'hFFFF_FFFF);
		send_bytes('{8'h30, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h02, 8'h80});
		send_item(1'b0, 8'h00, 32'd6);
		send_bytes('{8'h30, 8'h85});
		send_item(1'b0, 8'h00, 32'd3);
		send_bytes('{8'h30, 8'h81, 8'h00});
		send_item(1'b0, 8'h00, 32'd4);
		send_bytes('{8'h31, 8'h00});
		// restart in mid message
		send_item(1'b0, 8'h00, 32'd40);
		send_bytes('{8'h30, 8'h26});
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (3) send_object(build_object(), 0);
		wait (!hold_req);
		wait_drained();
	endtask

	task automatic test_random();
		int first;
		first = items_sent;
		while (items_sent - first < RandomItems) begin
			if (items_sent - first > RandomItems - QuietItems) idle_on = 1'b0;
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(5, 1))
					send_item(1'($urandom), 8'($urandom), $urandom);
			end else begin
				send_object(build_object(), $urandom_range(2) == 0 ? $urandom_range(5, 1) : 0);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		idle_on = 1'b0;
		hold_req = 1'b0;
		failures = 0;
		items_sent = 0;
		cycles = 0;
		clear_parse_state();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_zero_and_idle_bytes();
		test_hand_built();
		test_length_extremes();
		idle_on = 1'b1;
		test_backpressure();
		test_random();

		@(negedge clk);
		s_tvalid = 1'b0;
		wait_drained();
		if (failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: der_security_object_parser.f
rtl/dsop_pkg.sv
rtl/dsop_step.sv
rtl/der_security_object_parser.sv
sim/der_security_object_parser_tb.sv
